FILE: rtl/cau_pkg.sv
// shared codes and control types for the complex arithmetic unit
// no dependencies; used by cau_front, cau_cell and complex_arith_unit_top
package cau_pkg;

    // default sizes of the fixed point format
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // command codes
    localparam logic [3:0] CMD_ADD    = 4'd0;
    localparam logic [3:0] CMD_SUB    = 4'd1;
    localparam logic [3:0] CMD_MUL    = 4'd2;
    localparam logic [3:0] CMD_DIV    = 4'd3;
    localparam logic [3:0] CMD_RECIP  = 4'd4;
    localparam logic [3:0] CMD_MAG    = 4'd5;
    localparam logic [3:0] CMD_EQ     = 4'd6;
    localparam logic [3:0] CMD_NE     = 4'd7;
    localparam logic [3:0] CMD_ISZERO = 4'd8;
    localparam logic [3:0] CMD_ISREAL = 4'd9;
    localparam logic [3:0] CMD_ISIMAG = 4'd10;

    // what the cell chain does with a request
    typedef enum logic [1:0] {
        KIND_PRE  = 2'd0,   // result already final, carried along
        KIND_DIV  = 2'd1,   // one quotient bit per cell, two lanes
        KIND_SQRT = 2'd2    // one root bit per cell
    } t_kind;

    // control travelling with each request
    typedef struct packed {
        logic  vld;
        t_kind kind;
        logic  neg_re;
        logic  neg_im;
        logic  big_re;
        logic  big_im;
        logic  flag;
        logic  dz;
        logic  sat;
    } t_ctl;

endpackage

FILE: rtl/complex_arith_unit_top.sv
// complex fixed point alu: front end, chain of iteration cells, output register
// depends on cau_pkg, cau_front and cau_cell
//
// usage
//   input channel: i_valid / o_stall with i_cmd, i_a_re, i_a_im, i_b_re, i_b_im.
//   output channel: o_valid / i_stall with o_res_re, o_res_im, o_flag,
//   o_div_by_zero, o_saturated. a request moves when valid is high and stall low.
//   one result per request, in request order.
//   the path has three front stages (operands, products, sums), one cell per
//   quotient or root bit, and the output register. every command takes the
//   same path. throughput is one request per cycle while the output is not
//   stalled; the cell chain is fully pipelined and each cell produces one bit
//   for the request it holds. reset clears all valid bits; the block takes
//   requests on the next cycle. while the output waits under stall the whole
//   pipeline holds and o_stall is raised to the sender; nothing is dropped.
module complex_arith_unit_top #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [3:0]                   i_cmd,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic                         o_flag,
    output logic                         o_div_by_zero,
    output logic                         o_saturated
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;
    localparam int NW = 2 * DW + 2 * FRAC_BITS + 1;
    localparam logic [DW-1:0] RMAX = {1'b0, {(DW - 1){1'b1}}};
    localparam logic [DW-1:0] RMIN = {1'b1, {(DW - 1){1'b0}}};

    // global advance: hold everything while a result waits under stall
    logic en;
    logic r_out_vld;
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = r_out_vld && i_stall;

    // front end
    cau_pkg::t_ctl f_ctl;
    logic [PW-1:0] f_den;
    logic [NW-1:0] f_num_re, f_num_im;
    logic [DW-1:0] f_pre_re, f_pre_im;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_valid),
        .i_cmd    (i_cmd),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_ctl    (f_ctl),
        .o_den    (f_den),
        .o_num_re (f_num_re),
        .o_num_im (f_num_im),
        .o_pre_re (f_pre_re),
        .o_pre_im (f_pre_im)
    );

    // chain links
    cau_pkg::t_ctl c_ctl    [0:DW];
    logic [PW-1:0] c_den    [0:DW];
    logic [PW-1:0] c_rem_re [0:DW];
    logic [PW-1:0] c_rem_im [0:DW];
    logic [DW-1:0] c_num_re [0:DW];
    logic [DW-1:0] c_num_im [0:DW];
    logic [DW-1:0] c_q_re   [0:DW];
    logic [DW-1:0] c_q_im   [0:DW];

    // chain entry: overflow check on the high quotient bits, initial remainder
    logic [NW-1:0] hi_re, hi_im;

    always_comb begin
        hi_re       = f_num_re >> DW;
        hi_im       = f_num_im >> DW;
        c_ctl[0]    = f_ctl;
        c_den[0]    = f_den;
        c_rem_re[0] = '0;
        c_rem_im[0] = '0;
        c_num_re[0] = '0;
        c_num_im[0] = '0;
        c_q_re[0]   = '0;
        c_q_im[0]   = '0;
        case (f_ctl.kind)
            cau_pkg::KIND_DIV: begin
                c_ctl[0].big_re = (hi_re >= NW'(f_den));
                c_ctl[0].big_im = (hi_im >= NW'(f_den));
                c_rem_re[0]     = hi_re[PW-1:0];
                c_rem_im[0]     = hi_im[PW-1:0];
                c_num_re[0]     = f_num_re[DW-1:0];
                c_num_im[0]     = f_num_im[DW-1:0];
            end
            cau_pkg::KIND_PRE: begin
                c_q_re[0] = f_pre_re;
                c_q_im[0] = f_pre_im;
            end
            default: begin
            end
        endcase
    end

    // one cell per result bit
    for (genvar g = 0; g < DW; g++) begin : g_cell
        cau_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_ctl    (c_ctl[g]),
            .i_den    (c_den[g]),
            .i_rem_re (c_rem_re[g]),
            .i_rem_im (c_rem_im[g]),
            .i_num_re (c_num_re[g]),
            .i_num_im (c_num_im[g]),
            .i_q_re   (c_q_re[g]),
            .i_q_im   (c_q_im[g]),
            .o_ctl    (c_ctl[g+1]),
            .o_den    (c_den[g+1]),
            .o_rem_re (c_rem_re[g+1]),
            .o_rem_im (c_rem_im[g+1]),
            .o_num_re (c_num_re[g+1]),
            .o_num_im (c_num_im[g+1]),
            .o_q_re   (c_q_re[g+1]),
            .o_q_im   (c_q_im[g+1])
        );
    end

    // signed clamp of a quotient magnitude, {sat, value}
    function automatic logic [DW:0] f_qout(input logic [DW-1:0] q, input logic neg,
                                           input logic big);
        if (big) begin
            return {1'b1, neg ? RMIN : RMAX};
        end else if (!neg) begin
            return q[DW-1] ? {1'b1, RMAX} : {1'b0, q};
        end else if (q[DW-1] && (q[DW-2:0] != '0)) begin
            return {1'b1, RMIN};
        end
        return {1'b0, DW'(-q)};
    endfunction

    // final result formatting
    cau_pkg::t_ctl l_ctl;
    logic [DW:0]   d_re, d_im;
    logic [DW-1:0] n_re, n_im;
    logic          n_sat;

    always_comb begin
        l_ctl = c_ctl[DW];
        d_re  = f_qout(c_q_re[DW], l_ctl.neg_re, l_ctl.big_re);
        d_im  = f_qout(c_q_im[DW], l_ctl.neg_im, l_ctl.big_im);
        case (l_ctl.kind)
            cau_pkg::KIND_DIV: begin
                n_re  = d_re[DW-1:0];
                n_im  = d_im[DW-1:0];
                n_sat = d_re[DW] | d_im[DW];
            end
            cau_pkg::KIND_SQRT: begin
                n_re  = c_q_re[DW][DW-1] ? RMAX : c_q_re[DW];
                n_im  = '0;
                n_sat = c_q_re[DW][DW-1];
            end
            default: begin
                n_re  = c_q_re[DW];
                n_im  = c_q_im[DW];
                n_sat = l_ctl.sat;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld     <= l_ctl.vld;
            o_res_re      <= n_re;
            o_res_im      <= n_im;
            o_flag        <= l_ctl.flag;
            o_div_by_zero <= l_ctl.dz;
            o_saturated   <= n_sat;
        end
    end

    assign o_valid = r_out_vld;

    // checks
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_by_zero |-> o_res_re == '0 && o_res_im == '0 && !o_saturated)
        else $error("divide by zero result not cleared");

    a_flag_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flag |-> o_res_re == '0 && o_res_im == '0 && !o_div_by_zero
                              && !o_saturated)
        else $error("compare result carries arithmetic fields");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> o_valid)
        else $error("held result lost");

endmodule

FILE: rtl/cau_front.sv
// front end: operand register, product stage and combine stage
// depends on cau_pkg for command codes and the control struct
module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [3:0]                        i_cmd,
    input  logic signed [DATA_WIDTH-1:0]      i_a_re,
    input  logic signed [DATA_WIDTH-1:0]      i_a_im,
    input  logic signed [DATA_WIDTH-1:0]      i_b_re,
    input  logic signed [DATA_WIDTH-1:0]      i_b_im,
    output cau_pkg::t_ctl                     o_ctl,
    output logic [2*DATA_WIDTH-1:0]           o_den,
    output logic [2*DATA_WIDTH+2*FRAC_BITS:0] o_num_re,
    output logic [2*DATA_WIDTH+2*FRAC_BITS:0] o_num_im,
    output logic [DATA_WIDTH-1:0]             o_pre_re,
    output logic [DATA_WIDTH-1:0]             o_pre_im
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int NW = 2 * DW + 2 * FRAC_BITS + 1;
    localparam logic signed [SW:0] VMAX = {{(SW - DW + 2){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [SW:0] VMIN = {{(SW - DW + 2){1'b1}}, {(DW - 1){1'b0}}};

    // clamp to the signed result range, {sat, value}
    function automatic logic [DW:0] f_clamp(input logic signed [SW:0] v);
        if (v > VMAX) begin
            return {1'b1, VMAX[DW-1:0]};
        end else if (v < VMIN) begin
            return {1'b1, VMIN[DW-1:0]};
        end
        return {1'b0, v[DW-1:0]};
    endfunction

    // magnitude of a signed sum
    function automatic logic [SW-1:0] f_abs(input logic signed [SW-1:0] v);
        return v[SW-1] ? SW'(-v) : SW'(v);
    endfunction

    // stage a: operand register
    logic                 r_va;
    logic [3:0]           r_cmd_a;
    logic signed [DW-1:0] r_are_a, r_aim_a, r_bre_a, r_bim_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va    <= i_vld;
            r_cmd_a <= i_cmd;
            r_are_a <= i_a_re;
            r_aim_a <= i_a_im;
            r_bre_a <= i_b_re;
            r_bim_a <= i_b_im;
        end
    end

    // stage b: six parallel products
    logic signed [DW-1:0] sq1, sq2;
    logic signed [PW-1:0] n_p0, n_p1, n_p2, n_p3, n_p4, n_p5;

    always_comb begin
        sq1  = (r_cmd_a == cau_pkg::CMD_DIV) ? r_bre_a : r_are_a;
        sq2  = (r_cmd_a == cau_pkg::CMD_DIV) ? r_bim_a : r_aim_a;
        n_p0 = r_are_a * r_bre_a;
        n_p1 = r_aim_a * r_bim_a;
        n_p2 = r_are_a * r_bim_a;
        n_p3 = r_aim_a * r_bre_a;
        n_p4 = sq1 * sq1;
        n_p5 = sq2 * sq2;
    end

    logic                 r_vb;
    logic [3:0]           r_cmd_b;
    logic signed [DW-1:0] r_are_b, r_aim_b, r_bre_b, r_bim_b;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_vb    <= r_va;
            r_cmd_b <= r_cmd_a;
            r_are_b <= r_are_a;
            r_aim_b <= r_aim_a;
            r_bre_b <= r_bre_a;
            r_bim_b <= r_bim_a;
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_p4    <= n_p4;
            r_p5    <= n_p5;
        end
    end

    // stage c: sums, numerators and direct results
    logic signed [SW-1:0] s_mre, s_mim, s_nre, s_nim;
    logic [SW-1:0]        m_re, m_im;
    logic [PW-1:0]        s_den;
    logic [SW-1:0]        a_nre, a_nim;
    logic signed [SW:0]   v_re, v_im;
    logic [DW:0]          c_re, c_im;
    cau_pkg::t_ctl        n_ctl;
    logic [NW-1:0]        n_num_re, n_num_im;
    logic [DW-1:0]        n_pre_re, n_pre_im;

    always_comb begin
        s_mre = SW'(r_p0) - SW'(r_p1);
        s_mim = SW'(r_p2) + SW'(r_p3);
        s_den = $unsigned(r_p4) + $unsigned(r_p5);
        m_re  = f_abs(s_mre) >> FRAC_BITS;
        m_im  = f_abs(s_mim) >> FRAC_BITS;

        // numerators of the exact quotient
        if (r_cmd_b == cau_pkg::CMD_DIV) begin
            s_nre    = SW'(r_p0) + SW'(r_p1);
            s_nim    = SW'(r_p3) - SW'(r_p2);
            a_nre    = f_abs(s_nre);
            a_nim    = f_abs(s_nim);
            n_num_re = NW'(a_nre) << FRAC_BITS;
            n_num_im = NW'(a_nim) << FRAC_BITS;
        end else begin
            s_nre    = SW'(r_are_b);
            s_nim    = -SW'(r_aim_b);
            a_nre    = f_abs(s_nre);
            a_nim    = f_abs(s_nim);
            n_num_re = NW'(a_nre) << (2 * FRAC_BITS);
            n_num_im = NW'(a_nim) << (2 * FRAC_BITS);
        end

        v_re     = '0;
        v_im     = '0;
        c_re     = '0;
        c_im     = '0;
        n_ctl    = '0;
        n_ctl.vld  = r_vb;
        n_ctl.kind = cau_pkg::KIND_PRE;
        n_pre_re = '0;
        n_pre_im = '0;

        unique case (r_cmd_b)
            cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
                if (r_cmd_b == cau_pkg::CMD_SUB) begin
                    v_re = (SW+1)'(r_are_b) - (SW+1)'(r_bre_b);
                    v_im = (SW+1)'(r_aim_b) - (SW+1)'(r_bim_b);
                end else begin
                    v_re = (SW+1)'(r_are_b) + (SW+1)'(r_bre_b);
                    v_im = (SW+1)'(r_aim_b) + (SW+1)'(r_bim_b);
                end
                c_re      = f_clamp(v_re);
                c_im      = f_clamp(v_im);
                n_pre_re  = c_re[DW-1:0];
                n_pre_im  = c_im[DW-1:0];
                n_ctl.sat = c_re[DW] | c_im[DW];
            end
            cau_pkg::CMD_MUL: begin
                v_re = s_mre[SW-1] ? -$signed({1'b0, m_re}) : $signed({1'b0, m_re});
                v_im = s_mim[SW-1] ? -$signed({1'b0, m_im}) : $signed({1'b0, m_im});
                c_re      = f_clamp(v_re);
                c_im      = f_clamp(v_im);
                n_pre_re  = c_re[DW-1:0];
                n_pre_im  = c_im[DW-1:0];
                n_ctl.sat = c_re[DW] | c_im[DW];
            end
            cau_pkg::CMD_DIV, cau_pkg::CMD_RECIP: begin
                if (s_den == '0) begin
                    n_ctl.dz = 1'b1;
                end else begin
                    n_ctl.kind   = cau_pkg::KIND_DIV;
                    n_ctl.neg_re = s_nre[SW-1];
                    n_ctl.neg_im = s_nim[SW-1];
                end
            end
            cau_pkg::CMD_MAG: begin
                n_ctl.kind = cau_pkg::KIND_SQRT;
            end
            cau_pkg::CMD_EQ: begin
                n_ctl.flag = (r_are_b == r_bre_b) && (r_aim_b == r_bim_b);
            end
            cau_pkg::CMD_NE: begin
                n_ctl.flag = (r_are_b != r_bre_b) || (r_aim_b != r_bim_b);
            end
            cau_pkg::CMD_ISZERO: begin
                n_ctl.flag = (r_are_b == '0) && (r_aim_b == '0);
            end
            cau_pkg::CMD_ISREAL: begin
                n_ctl.flag = (r_aim_b == '0);
            end
            cau_pkg::CMD_ISIMAG: begin
                n_ctl.flag = (r_are_b == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl    <= n_ctl;
            o_den    <= s_den;
            o_num_re <= n_num_re;
            o_num_im <= n_num_im;
            o_pre_re <= n_pre_re;
            o_pre_im <= n_pre_im;
        end
    end

endmodule

FILE: rtl/cau_cell.sv
// one cell of the iteration chain: a quotient bit on two lanes or a root bit
// depends on cau_pkg for the control struct
module cau_cell #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  cau_pkg::t_ctl             i_ctl,
    input  logic [2*DATA_WIDTH-1:0]   i_den,
    input  logic [2*DATA_WIDTH-1:0]   i_rem_re,
    input  logic [2*DATA_WIDTH-1:0]   i_rem_im,
    input  logic [DATA_WIDTH-1:0]     i_num_re,
    input  logic [DATA_WIDTH-1:0]     i_num_im,
    input  logic [DATA_WIDTH-1:0]     i_q_re,
    input  logic [DATA_WIDTH-1:0]     i_q_im,
    output cau_pkg::t_ctl             o_ctl,
    output logic [2*DATA_WIDTH-1:0]   o_den,
    output logic [2*DATA_WIDTH-1:0]   o_rem_re,
    output logic [2*DATA_WIDTH-1:0]   o_rem_im,
    output logic [DATA_WIDTH-1:0]     o_num_re,
    output logic [DATA_WIDTH-1:0]     o_num_im,
    output logic [DATA_WIDTH-1:0]     o_q_re,
    output logic [DATA_WIDTH-1:0]     o_q_im
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;

    logic [PW:0]   t_re, t_im, d_ext;
    logic [DW+2:0] t_s, trial;
    logic [PW-1:0] n_den, n_rem_re, n_rem_im;
    logic [DW-1:0] n_num_re, n_num_im, n_q_re, n_q_im;

    // restoring divide step, square root step, or pass
    always_comb begin
        t_re     = {i_rem_re, i_num_re[DW-1]};
        t_im     = {i_rem_im, i_num_im[DW-1]};
        d_ext    = {1'b0, i_den};
        t_s      = {i_rem_re[DW:0], i_den[PW-1:PW-2]};
        trial    = {1'b0, i_q_re, 2'b01};
        n_den    = i_den;
        n_rem_re = i_rem_re;
        n_rem_im = i_rem_im;
        n_num_re = i_num_re;
        n_num_im = i_num_im;
        n_q_re   = i_q_re;
        n_q_im   = i_q_im;
        case (i_ctl.kind)
            cau_pkg::KIND_DIV: begin
                n_num_re = i_num_re << 1;
                n_num_im = i_num_im << 1;
                if (t_re >= d_ext) begin
                    n_rem_re = PW'(t_re - d_ext);
                    n_q_re   = {i_q_re[DW-2:0], 1'b1};
                end else begin
                    n_rem_re = PW'(t_re);
                    n_q_re   = {i_q_re[DW-2:0], 1'b0};
                end
                if (t_im >= d_ext) begin
                    n_rem_im = PW'(t_im - d_ext);
                    n_q_im   = {i_q_im[DW-2:0], 1'b1};
                end else begin
                    n_rem_im = PW'(t_im);
                    n_q_im   = {i_q_im[DW-2:0], 1'b0};
                end
            end
            cau_pkg::KIND_SQRT: begin
                // radicand sits in den, partial remainder in rem_re, root in q_re
                n_den = i_den << 2;
                if (t_s >= trial) begin
                    n_rem_re = PW'(t_s - trial);
                    n_q_re   = {i_q_re[DW-2:0], 1'b1};
                end else begin
                    n_rem_re = PW'(t_s);
                    n_q_re   = {i_q_re[DW-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl    <= i_ctl;
            o_den    <= n_den;
            o_rem_re <= n_rem_re;
            o_rem_im <= n_rem_im;
            o_num_re <= n_num_re;
            o_num_im <= n_num_im;
            o_q_re   <= n_q_re;
            o_q_im   <= n_q_im;
        end
    end

endmodule

FILE: bench/tb_complex_arith_unit_top.sv
// self-checking bench for complex_arith_unit_top: random and directed requests,
// own fixed point predictor, random sender gaps and receiver stalls
// depends on cau_pkg and the rtl of complex_arith_unit_top
`timescale 1ns / 100ps

module tb_complex_arith_unit_top;

    localparam int W = 32;
    localparam int RANDOM_REQS = 1450;
    localparam logic signed [159:0] Q_ONE  = 160'sd65536;
    localparam logic signed [159:0] Q_TWO32 = 160'sd1 <<< 32;

    typedef struct {
        logic [3:0]          cmd;
        logic signed [W-1:0] a_re, a_im, b_re, b_im;
    } t_req;

    typedef struct {
        logic [W-1:0] re, im;
        logic         flag, dz, sat;
    } t_res;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_valid = 1'b0, i_stall = 1'b0;
    logic [3:0] i_cmd = '0;
    logic signed [W-1:0] i_a_re = '0, i_a_im = '0, i_b_re = '0, i_b_im = '0;
    logic o_stall, o_valid, o_flag, o_div_by_zero, o_saturated;
    logic signed [W-1:0] o_res_re, o_res_im;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   accepted_cnt = 0, checked_cnt = 0, mismatch_cnt = 0, total_reqs = 0;
    int   phase;
    bit   feeding_done = 0;

    complex_arith_unit_top dut (.*);

    // clock, period 2 ns
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // clamp to the signed output range and note saturation
    function automatic logic [W-1:0] clamp_part(input logic signed [159:0] v,
                                                 inout logic sat);
        if (v > 160'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -160'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[W-1:0];
    endfunction

    function automatic logic [127:0] floor_root(input logic [127:0] v);
        logic [127:0] r, cand;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = r | (128'd1 << i);
            if (cand * cand <= v) r = cand;
        end
        return r;
    endfunction

    // fixed point model of one request
    function automatic t_res complex_result(input t_req q);
        logic signed [159:0] ar, ai, br, bi, re, im, den;
        t_res r;
        logic arith;
        ar = q.a_re; ai = q.a_im; br = q.b_re; bi = q.b_im;
        r = '{default: '0};
        arith = 1'b0;
        re = '0; im = '0;
        case (q.cmd)
            cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
                re = (q.cmd == cau_pkg::CMD_SUB) ? ar - br : ar + br;
                im = (q.cmd == cau_pkg::CMD_SUB) ? ai - bi : ai + bi;
                arith = 1'b1;
            end
            cau_pkg::CMD_MUL: begin
                re = (ar * br - ai * bi) / Q_ONE;
                im = (ar * bi + ai * br) / Q_ONE;
                arith = 1'b1;
            end
            cau_pkg::CMD_DIV, cau_pkg::CMD_RECIP: begin
                if (q.cmd == cau_pkg::CMD_DIV) begin
                    den = br * br + bi * bi;
                    re = (ar * br + ai * bi) * Q_ONE;
                    im = (ai * br - ar * bi) * Q_ONE;
                end else begin
                    den = ar * ar + ai * ai;
                    re = ar * Q_TWO32;
                    im = -ai * Q_TWO32;
                end
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    re = re / den;
                    im = im / den;
                    arith = 1'b1;
                end
            end
            cau_pkg::CMD_MAG: begin
                re = $signed({32'd0, floor_root(128'(ar * ar + ai * ai))});
                arith = 1'b1;
            end
            cau_pkg::CMD_EQ:     r.flag = (q.a_re == q.b_re) && (q.a_im == q.b_im);
            cau_pkg::CMD_NE:     r.flag = (q.a_re != q.b_re) || (q.a_im != q.b_im);
            cau_pkg::CMD_ISZERO: r.flag = (q.a_re == 0) && (q.a_im == 0);
            cau_pkg::CMD_ISREAL: r.flag = (q.a_im == 0);
            cau_pkg::CMD_ISIMAG: r.flag = (q.a_re == 0);
            default: ;
        endcase
        if (arith) begin
            r.re = clamp_part(re, r.sat);
            r.im = clamp_part(im, r.sat);
        end
        return r;
    endfunction

    // operand mix: zero, extremes, small values, full random
    function automatic logic signed [W-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return '0;
            1: case ($urandom_range(0, 5))
                   0: return 32'sh7fff_ffff;
                   1: return 32'sh8000_0000;
                   2: return -32'sd1;
                   3: return 32'sd1;
                   4: return 32'sd65536;
                   default: return -32'sd65536;
               endcase
            2, 3: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            default: return $urandom;
        endcase
    endfunction

    // request source: directed corners first, then random requests
    initial begin
        t_req q;
        logic signed [W-1:0] corner[6];
        corner = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sd65536, -32'sd1, 32'sd3};
        for (int c = 0; c <= int'(cau_pkg::CMD_ISIMAG); c++) begin
            pending_reqs.push_back('{4'(c), corner[0], corner[1], corner[1], corner[0]});
            pending_reqs.push_back('{4'(c), corner[3], corner[2], corner[2], corner[2]});
        end
        // divide by zero, recip of zero, exact compare hit, magnitude of two minimum values, unused command
        pending_reqs.push_back('{cau_pkg::CMD_DIV, corner[4], corner[5], 0, 0});
        pending_reqs.push_back('{cau_pkg::CMD_RECIP, 0, 0, corner[0], corner[1]});
        pending_reqs.push_back('{cau_pkg::CMD_EQ, corner[5], corner[4], corner[5], corner[4]});
        pending_reqs.push_back('{cau_pkg::CMD_MAG, corner[1], corner[1], 0, 0});
        pending_reqs.push_back('{4'd15, corner[0], corner[0], corner[0], corner[0]});
        for (int n = 0; n < RANDOM_REQS; n++) begin
            q.cmd  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                  : 4'($urandom_range(0, 10));
            q.a_re = pick_operand();
            q.a_im = pick_operand();
            q.b_re = pick_operand();
            q.b_im = pick_operand();
            if ($urandom_range(0, 3) == 0) begin
                q.b_re = q.a_re;
                q.b_im = q.a_im;
            end
            pending_reqs.push_back(q);
        end
        total_reqs = pending_reqs.size();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && expected_res.size() == 0 && !i_valid);
        repeat (60) @(posedge i_clk);
        $display("covered %0d requests, all eleven commands plus unused codes,", accepted_cnt);
        $display("%0d results checked under sender gaps and receiver stalls", checked_cnt);
        if (mismatch_cnt == 0 && expected_res.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // idling phase follows progress through the requests
    always_comb phase = (total_reqs == 0) ? 0 : (accepted_cnt * 4) / total_reqs;

    // request driver
    always @(posedge i_clk) begin
        automatic bit hold = i_valid && o_stall;
        automatic bit gap;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!hold) begin
            if (i_valid) begin
                expected_res.push_back(complex_result(pending_reqs.pop_front()));
                accepted_cnt++;
            end
            gap = (phase == 1) ? ($urandom_range(0, 99) < 54)
                : (phase == 3) ? ($urandom_range(0, 99) < 25) : 1'b0;
            if (pending_reqs.size() != 0 && !gap) begin
                i_valid <= 1'b1;
                i_cmd   <= pending_reqs[0].cmd;
                i_a_re  <= pending_reqs[0].a_re;
                i_a_im  <= pending_reqs[0].a_im;
                i_b_re  <= pending_reqs[0].b_re;
                i_b_im  <= pending_reqs[0].b_im;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_res.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result re=%h im=%h",
                                                 o_res_re, o_res_im);
            end else begin
                e = expected_res.pop_front();
                checked_cnt++;
                if (o_res_re !== e.re || o_res_im !== e.im || o_flag !== e.flag ||
                    o_div_by_zero !== e.dz || o_saturated !== e.sat) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"result %0d: exp re=%h im=%h f=%b dz=%b s=%b, ",
                                  "got re=%h im=%h f=%b dz=%b s=%b"},
                                 checked_cnt, e.re, e.im, e.flag, e.dz, e.sat,
                                 o_res_re, o_res_im, o_flag, o_div_by_zero, o_saturated);
                end
            end
        end
        i_stall <= (phase == 2) ? ($urandom_range(0, 99) < 54)
                 : (phase == 3) ? ($urandom_range(0, 99) < 25) : 1'b0;
    end

    // watchdog
    initial begin
        #1_000_000;
        $display("timeout waiting for results");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
